// ----- src/fip_pkg.sv -----
package fip_pkg;

    localparam int PT_W       = 32;
    localparam int OPA_W      = 33;
    localparam int OPB_W      = 30;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = 64;
    localparam int M_W        = 27;
    localparam int WZ_W       = 37;
    localparam int WZ_LO_W    = 24;
    localparam int PX_W       = 24;
    localparam int COEF_FRAC  = 28;
    localparam int PIX_FRAC   = 40;
    localparam int NORM_FRAC  = 24;
    localparam int STEP_W     = 5;
    localparam int UC_DEPTH   = 19;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int WIDTH_W    = 13;
    localparam int ZOOM_W     = 24;
    localparam int OFFSET_W   = 16;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        A_PX, A_PY, A_UX, A_M, A_WIDTH
    } a_sel_t;

    typedef enum logic [2:0] {
        B_COEF, B_RECIP_X, B_RECIP_Y, B_WZ_LO, B_WZ_HI, B_ZOOM
    } b_sel_t;

    typedef enum logic [2:0] {
        C_AX, C_BX, C_KX, C_AY, C_BY, C_KY
    } coef_idx_t;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD_K, ACC_ADD, ACC_ADD_SH24, ACC_LOAD_MUL,
        ACC_LOAD_OFF_X, ACC_LOAD_OFF_Y
    } acc_op_t;

    typedef enum logic [1:0] {
        J_NEXT, J_WAIT_IN, J_WAIT_OUT
    } jump_t;

    typedef enum logic [1:0] {
        MAP_STEM, MAP_BIG, MAP_LEFT, MAP_RIGHT
    } map_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_ZOOM, REG_OFFSET_X, REG_OFFSET_Y
    } cfg_reg_t;

    typedef struct packed {
        logic nx;
        logic ny;
        logic wz;
        logic m;
        logic px;
        logic py;
    } wr_t;

    typedef struct packed {
        a_sel_t    a_sel;
        b_sel_t    b_sel;
        coef_idx_t coef_b;
        coef_idx_t coef_k;
        acc_op_t   acc_op;
        wr_t       wr;
        jump_t     jump;
        step_t     target;
    } ctrl_word_t;

    localparam step_t STEP_IDLE = '0;

    localparam wr_t WR_NONE = '0;
    localparam wr_t WR_NX   = '{nx: 1'b1, default: 1'b0};
    localparam wr_t WR_NY   = '{ny: 1'b1, default: 1'b0};
    localparam wr_t WR_WZ   = '{wz: 1'b1, default: 1'b0};
    localparam wr_t WR_M    = '{m: 1'b1, default: 1'b0};
    localparam wr_t WR_PX   = '{px: 1'b1, default: 1'b0};
    localparam wr_t WR_PY   = '{py: 1'b1, default: 1'b0};

    function automatic longint qh(int n);
        return (longint'(n) * 268435456 + 50) / 100;
    endfunction

    function automatic longint rshift_round_c(longint v, int s);
        if (s == 0) begin
            return v;
        end
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    localparam longint SHIFT_A_Q28 = (64'sd2181887 * 268435456 + 500000) / 1000000;
    localparam longint RECIP_X = (64'sd1000000 * 268435456 + 2418826) / 4837653;
    localparam longint RECIP_Y = (64'sd1000000 * 268435456 + 4999129) / 9998258;

    localparam logic signed [OPB_W-1:0] QH_4   = OPB_W'(qh(4));
    localparam logic signed [OPB_W-1:0] QH_15  = OPB_W'(qh(15));
    localparam logic signed [OPB_W-1:0] QH_16  = OPB_W'(qh(16));
    localparam logic signed [OPB_W-1:0] QH_20  = OPB_W'(qh(20));
    localparam logic signed [OPB_W-1:0] QH_22  = OPB_W'(qh(22));
    localparam logic signed [OPB_W-1:0] QH_23  = OPB_W'(qh(23));
    localparam logic signed [OPB_W-1:0] QH_24  = OPB_W'(qh(24));
    localparam logic signed [OPB_W-1:0] QH_26  = OPB_W'(qh(26));
    localparam logic signed [OPB_W-1:0] QH_28  = OPB_W'(qh(28));
    localparam logic signed [OPB_W-1:0] QH_44  = OPB_W'(qh(44));
    localparam logic signed [OPB_W-1:0] QH_85  = OPB_W'(qh(85));
    localparam logic signed [OPB_W-1:0] QH_160 = OPB_W'(qh(160));

    function automatic logic signed [OPB_W-1:0] coef_value(map_t map, coef_idx_t idx);
        logic signed [OPB_W-1:0] c;
        c = '0;
        unique case (map)
            MAP_STEM: begin
                if (idx == C_BY) begin
                    c = QH_16;
                end
            end
            MAP_BIG: begin
                case (idx)
                    C_AX:    c = QH_85;
                    C_BX:    c = QH_4;
                    C_AY:    c = -QH_4;
                    C_BY:    c = QH_85;
                    C_KY:    c = QH_160;
                    default: c = '0;
                endcase
            end
            MAP_LEFT: begin
                case (idx)
                    C_AX:    c = QH_20;
                    C_BX:    c = -QH_26;
                    C_AY:    c = QH_23;
                    C_BY:    c = QH_22;
                    C_KY:    c = QH_160;
                    default: c = '0;
                endcase
            end
            MAP_RIGHT: begin
                case (idx)
                    C_AX:    c = -QH_15;
                    C_BX:    c = QH_28;
                    C_AY:    c = QH_26;
                    C_BY:    c = QH_24;
                    C_KY:    c = QH_44;
                    default: c = '0;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic ctrl_word_t mk(a_sel_t a, b_sel_t b, coef_idx_t cb, coef_idx_t ck,
                                      acc_op_t op, wr_t wr, jump_t j);
        ctrl_word_t w;
        w.a_sel  = a;
        w.b_sel  = b;
        w.coef_b = cb;
        w.coef_k = ck;
        w.acc_op = op;
        w.wr     = wr;
        w.jump   = j;
        w.target = STEP_IDLE;
        return w;
    endfunction

    // one multiply issued per step, its product is usable in the next step
    localparam ctrl_word_t UCODE [UC_DEPTH] = '{
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_HOLD,       WR_NONE, J_WAIT_IN),
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_LOAD_K,     WR_NONE, J_NEXT),
        mk(A_PY,    B_COEF,    C_BX, C_KX, ACC_ADD,        WR_NONE, J_NEXT),
        mk(A_WIDTH, B_ZOOM,    C_AX, C_KX, ACC_ADD,        WR_NONE, J_NEXT),
        mk(A_PX,    B_COEF,    C_AY, C_KY, ACC_LOAD_K,     wr_t'(WR_NX | WR_WZ), J_NEXT),
        mk(A_PY,    B_COEF,    C_BY, C_KY, ACC_ADD,        WR_NONE, J_NEXT),
        mk(A_UX,    B_RECIP_X, C_AX, C_KX, ACC_ADD,        WR_NONE, J_NEXT),
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_LOAD_MUL,   WR_NY,   J_NEXT),
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_HOLD,       WR_M,    J_NEXT),
        mk(A_M,     B_WZ_LO,   C_AX, C_KX, ACC_LOAD_OFF_X, WR_NONE, J_NEXT),
        mk(A_M,     B_WZ_HI,   C_AX, C_KX, ACC_ADD,        WR_NONE, J_NEXT),
        mk(A_PY,    B_RECIP_Y, C_AX, C_KX, ACC_ADD_SH24,   WR_NONE, J_NEXT),
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_LOAD_MUL,   WR_PX,   J_NEXT),
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_HOLD,       WR_M,    J_NEXT),
        mk(A_M,     B_WZ_LO,   C_AX, C_KX, ACC_LOAD_OFF_Y, WR_NONE, J_NEXT),
        mk(A_M,     B_WZ_HI,   C_AX, C_KX, ACC_ADD,        WR_NONE, J_NEXT),
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_ADD_SH24,   WR_NONE, J_NEXT),
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_HOLD,       WR_PY,   J_NEXT),
        mk(A_PX,    B_COEF,    C_AX, C_KX, ACC_HOLD,       WR_NONE, J_WAIT_OUT)
    };

endpackage

// ----- src/fip_datapath.sv -----
module fip_datapath import fip_pkg::*; #(
    parameter int FRAC_BITS  = 24,
    parameter int PIXEL_BITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ctrl_word_t                 ctrl,
    input  map_t                       map_sel,
    input  logic [WIDTH_W-1:0]         frame_width,
    input  logic [WIDTH_W-1:0]         frame_height,
    input  logic [ZOOM_W-1:0]          zoom,
    input  logic signed [OFFSET_W-1:0] offset_x,
    input  logic signed [OFFSET_W-1:0] offset_y,
    output logic [PIXEL_BITS-1:0]      pixel_x,
    output logic [PIXEL_BITS-1:0]      pixel_y,
    output logic                       in_frame
);

    localparam longint SHIFT_A    = rshift_round_c(SHIFT_A_Q28, COEF_FRAC - FRAC_BITS);
    localparam longint RND_PT     = longint'(1) << (COEF_FRAC - 1);
    localparam int     M_SHIFT    = FRAC_BITS + COEF_FRAC - NORM_FRAC;
    localparam longint RND_M      = longint'(1) << (M_SHIFT - 1);
    localparam longint M_HALF     = longint'(1) << (NORM_FRAC - 1);
    localparam longint M_LIM      = longint'(1) << (NORM_FRAC + 1);
    localparam longint PT_MAX     = (longint'(1) << (PT_W - 1)) - 1;
    localparam longint PT_MIN     = -(longint'(1) << (PT_W - 1));
    localparam longint TRUNC_BIAS = (longint'(1) << PIX_FRAC) - 1;
    localparam logic [PX_W-2:0] PIX_LIM = (PX_W - 1)'(1) << PIXEL_BITS;

    logic signed [PT_W-1:0]   point_x_reg, point_y_reg, nx_reg;
    logic signed [M_W-1:0]    m_reg, m_next;
    logic [WZ_W-1:0]          wz_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PX_W-1:0]   px_reg, py_reg, pix_next;
    logic signed [OPA_W-1:0]  op_a, ux;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [ACC_W-1:0]  k_val, r_pt, r_m, r_m_clamp, r_tr;
    logic signed [PT_W-1:0]   sat_pt;
    logic                     px_ok, py_ok;

    assign ux = OPA_W'(nx_reg) + OPA_W'(SHIFT_A);

    always_comb begin
        unique case (ctrl.a_sel)
            A_PX:    op_a = OPA_W'(point_x_reg);
            A_PY:    op_a = OPA_W'(point_y_reg);
            A_UX:    op_a = ux;
            A_M:     op_a = OPA_W'(m_reg);
            A_WIDTH: op_a = OPA_W'(frame_width);
            default: op_a = '0;
        endcase
    end

    always_comb begin
        unique case (ctrl.b_sel)
            B_COEF:    op_b = coef_value(map_sel, ctrl.coef_b);
            B_RECIP_X: op_b = OPB_W'(RECIP_X);
            B_RECIP_Y: op_b = OPB_W'(RECIP_Y);
            B_WZ_LO:   op_b = OPB_W'(wz_reg[WZ_LO_W-1:0]);
            B_WZ_HI:   op_b = OPB_W'(wz_reg[WZ_W-1:WZ_LO_W]);
            B_ZOOM:    op_b = OPB_W'(zoom);
            default:   op_b = '0;
        endcase
    end

    assign k_val = ACC_W'(coef_value(map_sel, ctrl.coef_k)) <<< FRAC_BITS;

    always_comb begin
        unique case (ctrl.acc_op)
            ACC_HOLD:       acc_next = acc_reg;
            ACC_LOAD_K:     acc_next = k_val;
            ACC_ADD:        acc_next = acc_reg + ACC_W'(mul_reg);
            ACC_ADD_SH24:   acc_next = acc_reg + (ACC_W'(mul_reg) <<< WZ_LO_W);
            ACC_LOAD_MUL:   acc_next = ACC_W'(mul_reg);
            ACC_LOAD_OFF_X: acc_next = ACC_W'(offset_x) <<< PIX_FRAC;
            ACC_LOAD_OFF_Y: acc_next = ACC_W'(offset_y) <<< PIX_FRAC;
            default:        acc_next = acc_reg;
        endcase
    end

    // new point coordinate: round at the coefficient fraction, then saturate
    always_comb begin
        r_pt = (acc_reg + RND_PT) >>> COEF_FRAC;
        if (r_pt > PT_MAX) begin
            sat_pt = PT_W'(PT_MAX);
        end else if (r_pt < PT_MIN) begin
            sat_pt = PT_W'(PT_MIN);
        end else begin
            sat_pt = PT_W'(r_pt);
        end
    end

    // normalized coordinate minus one half, clamped to [-2, 2]
    always_comb begin
        r_m = ((acc_reg + RND_M) >>> M_SHIFT) - M_HALF;
        if (r_m > M_LIM) begin
            r_m_clamp = M_LIM;
        end else if (r_m < -M_LIM) begin
            r_m_clamp = -M_LIM;
        end else begin
            r_m_clamp = r_m;
        end
        m_next = M_W'(r_m_clamp);
    end

    // truncate toward zero, then negate
    always_comb begin
        r_tr     = (acc_reg + (acc_reg[ACC_W-1] ? TRUNC_BIAS : 64'sd0)) >>> PIX_FRAC;
        pix_next = PX_W'(-r_tr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end else if (ctrl.wr.ny) begin
            point_x_reg <= nx_reg;
            point_y_reg <= sat_pt;
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= op_a * op_b;
        acc_reg <= acc_next;
        if (ctrl.wr.nx) begin
            nx_reg <= sat_pt;
        end
        if (ctrl.wr.wz) begin
            wz_reg <= mul_reg[WZ_W-1:0];
        end
        if (ctrl.wr.m) begin
            m_reg <= m_next;
        end
        if (ctrl.wr.px) begin
            px_reg <= pix_next;
        end
        if (ctrl.wr.py) begin
            py_reg <= pix_next;
        end
    end

    assign px_ok = !px_reg[PX_W-1] && (px_reg[PX_W-2:0] < (PX_W - 1)'(frame_width))
                   && (px_reg[PX_W-2:0] < PIX_LIM);
    assign py_ok = !py_reg[PX_W-1] && (py_reg[PX_W-2:0] < (PX_W - 1)'(frame_height))
                   && (py_reg[PX_W-2:0] < PIX_LIM);

    assign in_frame = px_ok && py_ok;
    assign pixel_x  = px_reg[PIXEL_BITS-1:0];
    assign pixel_y  = py_reg[PIXEL_BITS-1:0];

endmodule

// ----- src/fern_ifs_point_plotter.sv -----
// Fern chaos-game point plotter. Each transfer on the s_ side carries one uniform random
// fraction that picks one of the four fern affine maps; the stored point is moved by that
// map and projected to a pixel, and a transfer on the m_ side carries the pixel when it
// lies inside the frame (otherwise nothing comes out, though the point still moves). One
// item ends before the next is taken: a 19-step microprogram in a constant table runs
// the affine map, the normalization and the frame scaling through one shared multiplier
// and accumulator, one product per step. The pixel waits in an output register, so the
// next item starts even while it has not been taken. The user writes configuration via
// cfg_wr_en/cfg_addr/cfg_wdata only while no item is in flight; it is not enforced.
module fern_ifs_point_plotter import fip_pkg::*; #(
    parameter int FRAC_BITS   = 24,
    parameter int RANDOM_BITS = 16,
    parameter int PIXEL_BITS  = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]                cfg_addr,
    input  logic [CFG_DATA_W-1:0]                cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((RANDOM_BITS+7)/8)*8-1:0]     s_tdata,   // random_fraction
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((2*PIXEL_BITS+7)/8)*8-1:0]    m_tdata    // pixel_x, pixel_y
);

    localparam int     TD_W  = ((2 * PIXEL_BITS + 7) / 8) * 8;
    localparam longint THR_1 = ((longint'(1) << RANDOM_BITS) + 99) / 100;
    localparam longint THR_2 = ((longint'(86) << RANDOM_BITS) + 99) / 100;
    localparam longint THR_3 = ((longint'(93) << RANDOM_BITS) + 99) / 100;

    logic [WIDTH_W-1:0]         frame_width_reg, frame_height_reg;
    logic [ZOOM_W-1:0]          zoom_reg;
    logic signed [OFFSET_W-1:0] offset_x_reg, offset_y_reg;

    step_t            step_reg, step_next;
    ctrl_word_t       uc;
    map_t             map_reg, map_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [TD_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [RANDOM_BITS:0] r_ext;
    logic             in_xfer, out_free;
    logic [PIXEL_BITS-1:0] pixel_x, pixel_y;
    logic             in_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_W'(800);
            frame_height_reg <= WIDTH_W'(600);
            zoom_reg         <= ZOOM_W'(65536);
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[WIDTH_W-1:0];
                REG_ZOOM:         zoom_reg         <= cfg_wdata[ZOOM_W-1:0];
                REG_OFFSET_X:     offset_x_reg     <= cfg_wdata[OFFSET_W-1:0];
                REG_OFFSET_Y:     offset_y_reg     <= cfg_wdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    assign uc       = UCODE[step_reg];
    assign s_tready = (uc.jump == J_WAIT_IN);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign r_ext = {1'b0, s_tdata[RANDOM_BITS-1:0]};

    always_comb begin
        priority if (r_ext < THR_1[RANDOM_BITS:0]) begin
            map_next = MAP_STEM;
        end else if (r_ext < THR_2[RANDOM_BITS:0]) begin
            map_next = MAP_BIG;
        end else if (r_ext < THR_3[RANDOM_BITS:0]) begin
            map_next = MAP_LEFT;
        end else begin
            map_next = MAP_RIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            map_reg <= map_next;
        end
    end

    always_comb begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (uc.jump)
            J_NEXT: begin
                step_next = step_reg + STEP_W'(1);
            end
            J_WAIT_IN: begin
                if (in_xfer) begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            J_WAIT_OUT: begin
                if (out_free) begin
                    step_next = uc.target;
                    if (in_frame) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tdata_next[PIXEL_BITS-1:0]            = pixel_x;
                        m_tdata_next[2*PIXEL_BITS-1:PIXEL_BITS] = pixel_y;
                    end
                end
            end
            default: begin
                step_next = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    fip_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (uc),
        .map_sel      (map_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .zoom         (zoom_reg),
        .offset_x     (offset_x_reg),
        .offset_y     (offset_y_reg),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .in_frame     (in_frame)
    );

endmodule
